// ===== design/ssp_pkg.sv =====
// ============================================================================
// ssp_pkg
// Shared types and constants for the switch scan press classifier.
// ============================================================================
package ssp_pkg;

    localparam int unsigned MAX_SWITCHES = 16;
    localparam int unsigned IDX_W        = $clog2(MAX_SWITCHES);
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned THRESH_W     = 16;
    localparam int unsigned MASK_W       = 16;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [THRESH_W-1:0] EARLY_RELEASE_RESET = THRESH_W'(500);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_RELEASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_MASK   = CFG_IDX_W'(2);

    // per-switch state held in the state RAM
    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] edge_time;
    } sw_entry_t;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0] switch_index;
        logic             level;
        logic             pressed;
        logic             released_early;
        logic             released_late;
        logic             any_edge;
        logic             publish;
        logic             scan_wrap;
    } sw_result_t;

endpackage

// ===== design/ssp_state_ram.sv =====
// ============================================================================
// ssp_state_ram
// Per-switch state RAM, registered read, with per-entry valid
// bits so unwritten entries read as zero after reset.
// ============================================================================
module ssp_state_ram
    import ssp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output sw_entry_t        rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  sw_entry_t        wr_data
);

    sw_entry_t                mem [MAX_SWITCHES];
    logic [MAX_SWITCHES-1:0]  valid_reg;
    sw_entry_t                rd_data_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // read-before-write on a same-address collision; caller bypasses
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== design/ssp_classify.sv =====
// ============================================================================
// ssp_classify
// Edge detection and press/release classification for one switch sample.
// ============================================================================
module ssp_classify
    import ssp_pkg::*;
(
    input  sw_entry_t           prev,
    input  logic                pin_level,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [IDX_W-1:0]    idx,
    input  logic                count_zero,
    input  logic                scan_wrap,
    input  logic [THRESH_W-1:0] early_release_ms,
    input  logic [MASK_W-1:0]   public_mask,
    output sw_result_t          result,
    output sw_entry_t           next_entry
);

    logic              lvl;
    logic              edge_seen;
    logic [TIME_W-1:0] elapsed;
    logic              is_early;

    always_comb begin
        lvl       = ~pin_level;
        edge_seen = !count_zero && (lvl != prev.level);
        elapsed   = now_ms - prev.edge_time;  // modulo 2^32, wrap safe
        is_early  = elapsed < TIME_W'(early_release_ms);

        result.switch_index   = idx;
        result.level          = count_zero ? prev.level : lvl;
        result.pressed        = edge_seen && lvl;
        result.released_early = edge_seen && !lvl && is_early;
        result.released_late  = edge_seen && !lvl && !is_early;
        result.any_edge       = edge_seen;
        result.publish        = edge_seen && public_mask[idx];
        result.scan_wrap      = scan_wrap;

        next_entry.level     = lvl;
        next_entry.edge_time = edge_seen ? now_ms : prev.edge_time;
    end

endmodule

// ===== design/switch_scan_press_classifier_core.sv =====
// ============================================================================
// switch_scan_press_classifier_core
// Round-robin switch scanner: classifies each sample's edge as press, early or
// late release, keeping per-switch level and edge time in a small RAM.
// ============================================================================
//
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid s_ready s_pin_level s_now_ms    | in
//  result   | m_valid m_ready m_switch_index ...      | out
//  config   | cfg_valid cfg_ready cfg_index cfg_data  | in
//
//  One beat per cycle sustained while m_ready holds. RAM read on accept,
//  classify and write back in stage 1, result register after that: the
//  accept loads stage 1, and stage 1 advances into the result register.
//  Back-to-back beats on the same switch (switch_count of one) go through a
//  one-entry bypass that replaces the stale RAM read with the write-back.
//  Reset (aresetn low, synchronous) clears scan index, valid bits and config
//  to their reset values; no clearing pass is needed.
//  A stalled result holds stage 1; s_ready drops only when both are full.
// ============================================================================
module switch_scan_press_classifier_core
    import ssp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input samples
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pin_level,
    input  logic [TIME_W-1:0]     s_now_ms,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDX_W-1:0]      m_switch_index,
    output logic                  m_level,
    output logic                  m_pressed,
    output logic                  m_released_early,
    output logic                  m_released_late,
    output logic                  m_any_edge,
    output logic                  m_publish,
    output logic                  m_scan_wrap,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]  switch_count_reg;
    logic [THRESH_W-1:0] early_release_reg;
    logic [MASK_W-1:0]   public_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_count_reg  <= '0;
            early_release_reg <= EARLY_RELEASE_RESET;
            public_mask_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SWITCH_COUNT:  switch_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_EARLY_RELEASE: early_release_reg <= cfg_data[THRESH_W-1:0];
                CFG_PUBLIC_MASK:   public_mask_reg   <= cfg_data[MASK_W-1:0];
                default: ;  // unknown register, ignored
            endcase
        end
    end

    // clamp to the number of RAM entries
    logic [COUNT_W-1:0] count_eff;
    logic               count_zero;

    assign count_eff  = (switch_count_reg > COUNT_W'(MAX_SWITCHES))
                        ? COUNT_W'(MAX_SWITCHES) : switch_count_reg;
    assign count_zero = (count_eff == '0);

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic s_accept;
    logic s1_valid_reg;
    logic s1_advance;
    logic m_valid_reg;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;

    // ------------------------------------------------------------------
    // Scan index: advances at accept, stage 1 carries the sampled index
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   scan_index_reg;
    logic [IDX_W-1:0]   scan_index_next;
    logic [COUNT_W-1:0] idx_plus_one;

    always_comb begin
        idx_plus_one = COUNT_W'(scan_index_reg) + COUNT_W'(1);
        if (count_zero) begin
            scan_index_next = scan_index_reg;
        end else if (idx_plus_one >= count_eff) begin
            // also covers an index left above a lowered count
            scan_index_next = '0;
        end else begin
            scan_index_next = idx_plus_one[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_index_reg <= '0;
        end else if (s_accept) begin
            scan_index_reg <= scan_index_next;
        end
    end

    // stage 1 payload
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_pin_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_wrap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_idx_reg  <= scan_index_reg;
            s1_pin_reg  <= s_pin_level;
            s1_now_reg  <= s_now_ms;
            s1_wrap_reg <= (scan_index_next == '0);
        end
    end

    // ------------------------------------------------------------------
    // State RAM with write-back bypass
    // ------------------------------------------------------------------
    sw_entry_t  ram_rd_data;
    sw_entry_t  wr_entry;
    sw_entry_t  prev_entry;
    sw_result_t s1_result;
    logic       wr_en;

    // count of zero leaves all state untouched
    assign wr_en = s1_advance && !count_zero;

    ssp_state_ram u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (scan_index_reg),
        .rd_data (ram_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (wr_entry)
    );

    // the RAM read for a beat accepted in the same cycle as a write to the
    // same switch returns old data; keep the written entry instead
    logic      byp_valid_reg;
    sw_entry_t byp_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (s_accept) begin
            byp_valid_reg <= wr_en && (s1_idx_reg == scan_index_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byp_data_reg <= wr_entry;
        end
    end

    assign prev_entry = byp_valid_reg ? byp_data_reg : ram_rd_data;

    ssp_classify u_classify (
        .prev             (prev_entry),
        .pin_level        (s1_pin_reg),
        .now_ms           (s1_now_reg),
        .idx              (s1_idx_reg),
        .count_zero       (count_zero),
        .scan_wrap        (s1_wrap_reg),
        .early_release_ms (early_release_reg),
        .public_mask      (public_mask_reg),
        .result           (s1_result),
        .next_entry       (wr_entry)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    sw_result_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            out_reg <= s1_result;
        end
    end

    assign m_switch_index   = out_reg.switch_index;
    assign m_level          = out_reg.level;
    assign m_pressed        = out_reg.pressed;
    assign m_released_early = out_reg.released_early;
    assign m_released_late  = out_reg.released_late;
    assign m_any_edge       = out_reg.any_edge;
    assign m_publish        = out_reg.publish;
    assign m_scan_wrap      = out_reg.scan_wrap;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // an edge is exactly one of press, early release, late release
    a_edge_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_any_edge |->
            $onehot({m_pressed, m_released_early, m_released_late}))
        else $error("edge beat without a single classification");

    // no edge means no classification and nothing published
    a_no_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_any_edge |->
            !(m_pressed || m_released_early || m_released_late || m_publish))
        else $error("classification flag set without an edge");

    // the wrap flag carried in stage 1 matches the scan index left behind
    a_wrap_track: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_wrap_reg == (scan_index_reg == '0))
        else $error("scan wrap flag out of step with scan index");

    // a bypass hit only follows a write-back
    a_bypass_src: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !wr_en |=> !byp_valid_reg)
        else $error("bypass set without a write-back");
`endif

endmodule
